@@ rtl/bkl_pkg.sv @@
// ----------------------------------------------------------------------------
// bkl_pkg: shared definitions for the bucketed key lookup
// Sizes, field types, command and status codes, the key-memory request
// bundle and helper functions used by the lookup modules.
// ----------------------------------------------------------------------------
package bkl_pkg;

  // Table geometry
  localparam int BUCKET_DEPTH = 64;
  localparam int NUM_BUCKETS  = 10;
  localparam int MEM_DEPTH    = NUM_BUCKETS * BUCKET_DEPTH;

  // Key layout: nine BCD digits, leading digit picks the bucket
  localparam int KEY_DIGITS = 9;
  localparam int DIGIT_W    = 4;
  localparam int DIGIT_MAX  = 9;
  localparam int KEY_W      = KEY_DIGITS * DIGIT_W;
  localparam int BKT_W      = DIGIT_W;
  localparam int TAIL_W     = KEY_W - BKT_W;

  // Derived widths
  localparam int CNT_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int IDX_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [TAIL_W-1:0] tail_t;
  typedef logic [BKT_W-1:0]  bkt_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Key memory access for one cycle
  typedef struct packed {
    logic  we;
    addr_t waddr;
    tail_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  // One result transaction
  typedef struct packed {
    logic    found;
    status_t status;
  } rsp_t;

  // True when all nibbles of the key are decimal digits
  function automatic logic key_is_bcd(key_t k);
    logic ok;
    ok = 1'b1;
    for (int n = 0; n < KEY_DIGITS; n++) begin
      if (k[n*DIGIT_W +: DIGIT_W] > DIGIT_W'(DIGIT_MAX)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Flat memory address of an entry within a bucket
  function automatic addr_t entry_addr(bkt_t b, idx_t i);
    return addr_t'(b) * addr_t'(BUCKET_DEPTH) + addr_t'(i);
  endfunction

endpackage

@@ rtl/bkl_ifs.sv @@
// ----------------------------------------------------------------------------
// bkl_ifs: channel interfaces of the bucketed key lookup
// Ready/valid channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface bkl_req_if import bkl_pkg::*; ;
  logic valid;
  logic ready;
  logic cmd;
  key_t key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface bkl_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [1:0] status;

  modport source (output valid, output found, output status, input ready);
  modport sink   (input valid, input found, input status, output ready);
endinterface

@@ rtl/bkl_key_ram.sv @@
// ----------------------------------------------------------------------------
// bkl_key_ram: key entry memory
// Single write port and single read port, read data registered.
// ----------------------------------------------------------------------------
module bkl_key_ram import bkl_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output tail_t    rdata
);

  tail_t mem [MEM_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ rtl/bkl_ctrl.sv @@
// ----------------------------------------------------------------------------
// bkl_ctrl: lookup sequencer
// Checks the key, keeps the per-bucket fill counts, appends entries on insert
// and scans one bucket entry per cycle on search.
// ----------------------------------------------------------------------------
module bkl_ctrl import bkl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  logic     req_cmd,
  input  key_t     req_key,
  output ram_req_t ram_req,
  input  tail_t    ram_rdata,
  output logic     res_valid,
  input  logic     res_ready,
  output rsp_t     res
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t  state;
  cnt_t    counts [NUM_BUCKETS];
  bkt_t    bucket;
  tail_t   tail;
  cnt_t    cnt;
  cnt_t    idx;
  logic    found;
  status_t status;

  logic    accept;
  logic    key_ok;
  bkt_t    in_bkt;
  tail_t   in_tail;
  cnt_t    in_cnt;
  logic    has_room;
  logic    match;
  logic    scan_end;

  // Decode the incoming transaction
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign key_ok    = key_is_bcd(req_key);
  assign in_bkt    = req_key[KEY_W-1 -: BKT_W];
  assign in_tail   = req_key[TAIL_W-1:0];
  assign in_cnt    = key_ok ? counts[in_bkt] : '0;
  assign has_room  = (in_cnt < cnt_t'(BUCKET_DEPTH));

  // Compare the entry read in the previous cycle
  assign match    = (ram_rdata == tail);
  assign scan_end = (idx == cnt);

  // Drive the key memory
  always_comb begin
    ram_req = '0;
    if (accept && key_ok) begin
      if (req_cmd == CMD_INSERT) begin
        ram_req.we    = has_room;
        ram_req.waddr = entry_addr(in_bkt, in_cnt[IDX_W-1:0]);
        ram_req.wdata = in_tail;
      end else begin
        ram_req.re    = (in_cnt != '0);
        ram_req.raddr = entry_addr(in_bkt, '0);
      end
    end else if (state == S_SCAN && !match && !scan_end) begin
      ram_req.re    = 1'b1;
      ram_req.raddr = entry_addr(bucket, idx[IDX_W-1:0]);
    end
  end

  // Advance the sequencer and update fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        counts[b] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!key_ok) begin
              state <= S_RESULT;
            end else if (req_cmd == CMD_INSERT) begin
              if (has_room) begin
                counts[in_bkt] <= in_cnt + cnt_t'(1);
              end
              state <= S_RESULT;
            end else if (in_cnt == '0) begin
              state <= S_RESULT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match || scan_end) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the transaction and build the result
  always_ff @(posedge clk) begin
    if (accept) begin
      bucket <= in_bkt;
      tail   <= in_tail;
      cnt    <= in_cnt;
      idx    <= cnt_t'(1);
      found  <= 1'b0;
      if (!key_ok) begin
        status <= ST_BAD_DIGIT;
      end else if (req_cmd == CMD_INSERT && !has_room) begin
        status <= ST_FULL;
      end else begin
        status <= ST_OK;
      end
    end else if (state == S_SCAN) begin
      if (match) begin
        found <= 1'b1;
      end else if (!scan_end) begin
        idx <= idx + cnt_t'(1);
      end
    end
  end

  assign res_valid  = (state == S_RESULT);
  assign res.found  = found;
  assign res.status = status;

endmodule

@@ rtl/bucketed_key_lookup_top.sv @@
// ----------------------------------------------------------------------------
// bucketed_key_lookup_top: bucketed BCD key store with insert and search
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    cmd (0 insert, 1 search), key (9 BCD digits)
//   rsp      out  valid/ready    found, status (0 ok, 1 bad digit, 2 full)
//
// Insert and rejected keys go from accept straight to the result state; a search
// first scans its bucket, comparing at most BUCKET_DEPTH entries.
// The single read port of the key memory sets the scan at one entry per cycle.
// Reset clears the bucket fill counts; key memory contents are kept.
// A finished result waits in the output register while the next transaction
// is accepted; one transaction is in the sequencer at a time.
// ----------------------------------------------------------------------------
module bucketed_key_lookup_top import bkl_pkg::*; (
  input logic      clk,
  input logic      rst,
  bkl_req_if.sink  req,
  bkl_rsp_if.source rsp
);

  ram_req_t ram_req;
  tail_t    ram_rdata;
  logic     res_valid;
  logic     res_ready;
  rsp_t     res;

  logic       out_valid;
  logic       out_found;
  logic [1:0] out_status;

  bkl_key_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  bkl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_cmd   (req.cmd),
    .req_key   (req.key),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_found  <= res.found;
      out_status <= res.status;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.found  = out_found;
  assign rsp.status = out_status;

  // A hit is only reported with an ok status
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.found && rsp.status != ST_OK))
    else $error("found set on a result with non-ok status");

  // The sequencer holds one transaction at a time
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("input accepted on consecutive cycles");

  // No result is pending while the sequencer is waiting for input
  assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !res_valid)
    else $error("result pending while idle");

  // Memory writes and reads never share a cycle
  assert property (@(posedge clk) disable iff (rst)
    !(ram_req.we && ram_req.re))
    else $error("key memory read and write in the same cycle");

endmodule

@@ dv/bucketed_key_lookup_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bucketed_key_lookup_top_tb: self-checking bench for the bucketed key lookup
// Sends insert and search commands over the request channel and compares each
// result transaction with a behavioral copy of the bucket table. A directed
// pass covers empty buckets, hits, misses, duplicates and malformed digits.
// A random pass fills some buckets to overflow and searches stored keys. Both
// channels idle at random, and the result side holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module bucketed_key_lookup_top_tb;
  import bkl_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1430;
  localparam int unsigned PAUSE_AT_ITEM  = 700;
  localparam int unsigned HOLDOFF_AFTER  = 300;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int          HOT_BUCKET_A   = 2;
  localparam int          HOT_BUCKET_B   = 7;

  // Behavioral copy of the bucket table and the queue of pending results
  class lookup_scoreboard;
    int unsigned fill [NUM_BUCKETS];
    tail_t       entries [NUM_BUCKETS][BUCKET_DEPTH];
    rsp_t        expected_q [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      foreach (fill[b]) fill[b] = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Predict the result of one accepted command and update the table
    function void note_request(logic c, key_t k);
      rsp_t  r;
      bit    digits_ok;
      int    b;
      tail_t tail;
      digits_ok = 1'b1;
      for (int n = 0; n < KEY_DIGITS; n++) begin
        if (int'(k[n*DIGIT_W +: DIGIT_W]) > DIGIT_MAX) begin
          digits_ok = 1'b0;
        end
      end
      r.found  = 1'b0;
      r.status = ST_OK;
      if (!digits_ok) begin
        r.status = ST_BAD_DIGIT;
      end else begin
        b    = int'(k[KEY_W-1 -: BKT_W]);
        tail = k[TAIL_W-1:0];
        if (c == CMD_INSERT) begin
          if (fill[b] >= BUCKET_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            entries[b][fill[b]] = tail;
            fill[b]++;
          end
        end else begin
          for (int i = 0; i < fill[b]; i++) begin
            if (entries[b][i] == tail) begin
              r.found = 1'b1;
            end
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    // Compare one result transaction with the oldest prediction
    function void check_response(logic f, logic [1:0] s);
      rsp_t want;
      if (expected_q.size() == 0) begin
        $error("result with no command outstanding: found=%0d status=%0d", f, s);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (f !== want.found) begin
        $error("found mismatch: expected %0d, got %0d", want.found, f);
        mismatches++;
      end
      if (s !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, s);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bkl_req_if req_ch ();
  bkl_rsp_if rsp_ch ();

  bucketed_key_lookup_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lookup_scoreboard sb = new();

  key_t        inserted_keys [$];
  int unsigned idle_cycles = 0;
  int unsigned sink_hold   = 0;
  bit          holdoff_done = 1'b0;

  always #5 clk = ~clk;

  // Short gaps mostly, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Well-formed key in a given bucket with random trailing digits
  function automatic key_t random_bcd(int bkt);
    key_t k;
    k[KEY_W-1 -: BKT_W] = BKT_W'(bkt);
    for (int n = 0; n < KEY_DIGITS - 1; n++) begin
      k[n*DIGIT_W +: DIGIT_W] = DIGIT_W'($urandom_range(0, DIGIT_MAX));
    end
    return k;
  endfunction

  // Choose one random command: mostly inserts and searches of known keys
  task automatic pick_item(output logic c, output key_t k);
    int unsigned r;
    int unsigned choice;
    int unsigned pos;
    logic [DIGIT_W-1:0] digit;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // corrupt one to three digits
      c = 1'($urandom_range(0, 1));
      k = random_bcd($urandom_range(0, NUM_BUCKETS - 1));
      repeat ($urandom_range(1, 3)) begin
        pos = $urandom_range(0, KEY_DIGITS - 1);
        k[pos*DIGIT_W +: DIGIT_W] = DIGIT_W'($urandom_range(DIGIT_MAX + 1, 15));
      end
    end else if (r < 54) begin
      c = CMD_INSERT;
      choice = $urandom_range(0, 9);
      if (inserted_keys.size() != 0 && choice == 0) begin
        k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      end else if (choice < 5) begin
        // steer toward two buckets so that they overflow
        k = random_bcd($urandom_range(0, 1) ? HOT_BUCKET_A : HOT_BUCKET_B);
      end else begin
        k = random_bcd($urandom_range(0, NUM_BUCKETS - 1));
      end
      inserted_keys.push_back(k);
    end else begin
      c = CMD_SEARCH;
      choice = $urandom_range(0, 9);
      if (inserted_keys.size() != 0 && choice < 6) begin
        k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      end else if (inserted_keys.size() != 0 && choice < 8) begin
        // near miss: bump one trailing digit of a stored key
        k     = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        pos   = $urandom_range(0, KEY_DIGITS - 2);
        digit = k[pos*DIGIT_W +: DIGIT_W];
        k[pos*DIGIT_W +: DIGIT_W] = (int'(digit) == DIGIT_MAX) ? '0 : digit + 1'b1;
      end else begin
        k = random_bcd($urandom_range(0, NUM_BUCKETS - 1));
      end
    end
  endtask

  // Offer one command after an optional gap and hold it until accepted
  task automatic send_item(logic c, key_t k, int unsigned gap);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd   <= c;
    req_ch.key   <= k;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Directed pass: empty bucket, hit, miss, extremes, duplicates, bad digits
  task automatic run_directed();
    key_t k;
    send_item(CMD_SEARCH, 36'h000000000, gap_len());
    send_item(CMD_INSERT, 36'h000000000, gap_len());
    send_item(CMD_SEARCH, 36'h000000000, gap_len());
    send_item(CMD_INSERT, 36'h999999999, gap_len());
    send_item(CMD_SEARCH, 36'h999999999, gap_len());
    send_item(CMD_SEARCH, 36'h999999990, gap_len());
    send_item(CMD_INSERT, 36'h123456789, gap_len());
    send_item(CMD_INSERT, 36'h123456789, gap_len());
    send_item(CMD_SEARCH, 36'h123456789, gap_len());
    send_item(CMD_INSERT, 36'hFFFFFFFFF, gap_len());
    send_item(CMD_SEARCH, 36'hFFFFFFFFF, gap_len());
    for (int n = 0; n < KEY_DIGITS; n++) begin
      k = 36'h555555555;
      k[n*DIGIT_W +: DIGIT_W] = DIGIT_W'(DIGIT_MAX + 1 + (n % 6));
      send_item((n % 2 == 0) ? CMD_INSERT : CMD_SEARCH, k, gap_len());
    end
    // rejected inserts must leave the bucket empty
    send_item(CMD_SEARCH, 36'h5A5555555, gap_len());
    send_item(CMD_SEARCH, 36'h555555555, gap_len());
  endtask

  // Note accepted commands and check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.cmd, req_ch.key);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_response(rsp_ch.found, rsp_ch.status);
      end
    end
  end

  // Drive result ready: random stalls, quiet stretches, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold    <= sink_hold - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!holdoff_done && sb.checked >= HOLDOFF_AFTER) begin
      holdoff_done <= 1'b1;
      sink_hold    <= HOLDOFF_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if ((sb.checked / 150) % 3 == 2) begin
      rsp_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      sink_hold    <= gap_len();
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Abort when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Reset, stimulus and end of run
  initial begin
    logic        c;
    key_t        k;
    int unsigned gap;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.cmd   <= CMD_INSERT;
    req_ch.key   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      pick_item(c, k);
      // drain the block completely once
      if (i == PAUSE_AT_ITEM) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      gap = ((i / 120) % 4 == 1) ? 0 : gap_len();
      send_item(c, k, gap);
    end
    req_ch.valid <= 1'b0;

    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
